// ===== sv/tcm_pkg.sv =====
// Package: shared types, constants and wave functions for the texture coordinate modifier.
`timescale 1ns / 1ps

package tcm_pkg;

    localparam int WAVE_TABLE_SIZE = 1024;
    localparam int WAVE_LOG        = $clog2(WAVE_TABLE_SIZE);
    localparam int FRACTION_BITS   = 16;

    localparam longint ONE_VAL  = longint'(1) << FRACTION_BITS;
    localparam longint HALF_VAL = longint'(1) << (FRACTION_BITS - 1);

    // phase word is Q40; position is shifted into it by this much
    localparam int TURB_SH = 30 - FRACTION_BITS;
    localparam int Q22_R   = (FRACTION_BITS <= 22) ? 22 - FRACTION_BITS : 0;
    localparam int Q22_L   = (FRACTION_BITS > 22) ? FRACTION_BITS - 22 : 0;

    // reciprocal 2^(F+22)/w: numerator and quotient width
    localparam int RECIP_QW = FRACTION_BITS + 23;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODES = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIME = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURB       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL     = 4'd7;

    localparam logic [2:0] WAVE_NONE     = 3'd0;
    localparam logic [2:0] WAVE_SINE     = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_SAW      = 3'd4;
    localparam logic [2:0] WAVE_ISAW     = 3'd5;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef struct packed {
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic               last_out;
    } out_item_t;

    // configuration as the datapath sees it, with the per-frame terms worked out
    typedef struct packed {
        logic [2:0]         smode;
        logic [2:0]         tmode;
        logic signed [31:0] trans_u;
        logic signed [31:0] trans_v;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
        logic signed [31:0] recip;
        logic signed [31:0] scale_u;
        logic signed [31:0] scale_v;
        logic [39:0]        turb_phase;
        logic signed [15:0] turb_base;
        logic signed [15:0] turb_amp;
        logic signed [47:0] scroll_u;
        logic signed [47:0] scroll_v;
    } cfg_view_t;

    typedef logic signed [15:0] sine_tab_t [WAVE_TABLE_SIZE];

    // Q1.14 sine by integer Taylor series over the first quadrant
    function automatic sine_tab_t build_sine();
        sine_tab_t         tab;
        longint unsigned   a;
        longint unsigned   x;
        longint unsigned   mag;
        longint            sum;
        longint            r;
        bit                neg;
        for (int k = 0; k < WAVE_TABLE_SIZE; k++)
        begin
            neg = 1'b0;
            if (k <= WAVE_TABLE_SIZE / 4)
                a = k;
            else if (k <= WAVE_TABLE_SIZE / 2)
                a = WAVE_TABLE_SIZE / 2 - k;
            else if (k <= 3 * WAVE_TABLE_SIZE / 4)
            begin
                a   = k - WAVE_TABLE_SIZE / 2;
                neg = 1'b1;
            end
            else
            begin
                a   = WAVE_TABLE_SIZE - k;
                neg = 1'b1;
            end
            x   = (a * 4 * HALF_PI_Q30 + WAVE_TABLE_SIZE / 2) / WAVE_TABLE_SIZE;
            mag = x;
            sum = longint'(x);
            for (int i = 1; i <= 7; i++)
            begin
                mag = (mag * x) >> 30;
                mag = (mag * x) >> 30;
                mag = mag / TAYLOR_DIV[i];
                if (i % 2 == 1)
                    sum = sum - longint'(mag);
                else
                    sum = sum + longint'(mag);
            end
            if (sum < 0)
                sum = 0;
            r = (sum + 32768) >>> 16;
            if (r > 16384)
                r = 16384;
            tab[k] = 16'(neg ? -r : r);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_ROM = build_sine();

    function automatic logic signed [16:0] table_value(input logic [2:0] mode,
                                                       input logic [WAVE_LOG-1:0] k);
        int                 ki;
        int                 four;
        logic signed [16:0] tv;
        ki   = int'(k);
        four = (ki * 65536) >>> WAVE_LOG;
        unique case (mode)
            WAVE_SINE:     tv = 17'(SINE_ROM[k]);
            WAVE_TRIANGLE:
            begin
                if (ki < WAVE_TABLE_SIZE / 4)
                    tv = 17'(four);
                else if (ki < 3 * WAVE_TABLE_SIZE / 4)
                    tv = 17'(32768 - four);
                else
                    tv = 17'(four - 65536);
            end
            WAVE_SQUARE:   tv = (ki < WAVE_TABLE_SIZE / 2) ? 17'sd16384 : -17'sd16384;
            WAVE_SAW:      tv = 17'((ki * 16384) >>> WAVE_LOG);
            WAVE_ISAW:     tv = 17'(16384 - ((ki * 16384) >>> WAVE_LOG));
            default:       tv = '0;
        endcase
        return tv;
    endfunction

    function automatic logic wave_on(input logic [2:0] mode);
        return (mode >= WAVE_SINE) && (mode <= WAVE_ISAW);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
        logic signed [31:0] y;
        if (x > 72'sd2147483647)
            y = 32'sh7fffffff;
        else if (x < -72'sd2147483648)
            y = 32'sh80000000;
        else
            y = x[31:0];
        return y;
    endfunction

    function automatic logic signed [40:0] q22_to_coord(input logic signed [32:0] w);
        return (41'(w) >>> Q22_R) <<< Q22_L;
    endfunction

endpackage

// ===== sv/tcm_recip_div.sv =====
// Restoring divider: 2^(F+22) divided by an unsigned divisor, one quotient bit a cycle.
`timescale 1ns / 1ps

module tcm_recip_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [31:0]                   divisor,
    output logic                          done,
    output logic [tcm_pkg::RECIP_QW-1:0]  quotient
);

    localparam int QW  = tcm_pkg::RECIP_QW;
    localparam int CNW = $clog2(QW + 1);

    logic            run_reg;
    logic            done_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [32:0]     rem_reg;
    logic [QW-1:0]   quo_reg;
    logic [QW-1:0]   num_reg;
    logic [31:0]     den_reg;
    logic [32:0]     trial;
    logic            qbit;

    always_comb
    begin
        trial = {rem_reg[31:0], num_reg[QW-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNW'(QW);
                rem_reg <= '0;
                quo_reg <= '0;
                num_reg <= QW'(1) << (QW - 1);
                den_reg <= divisor;
            end
            else if (run_reg)
            begin
                rem_reg <= qbit ? (trial - {1'b0, den_reg}) : trial;
                quo_reg <= {quo_reg[QW-2:0], qbit};
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> run_reg) else $error("divider did not start");
`endif

endmodule

// ===== sv/tcm_config.sv =====
// Configuration registers and the per-frame terms derived from them.
`timescale 1ns / 1ps

module tcm_config (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data,
    output logic                              busy,
    output tcm_pkg::cfg_view_t                cfg
);

    typedef enum logic [2:0] {
        CS_IDLE, CS_MUL, CS_PHASE, CS_LOOK, CS_WAVE, CS_DSTART, CS_DIV
    } cstate_t;

    cstate_t state_reg, state_next;

    logic [5:0]  wave_modes_reg;
    logic [31:0] frame_time_reg;
    logic [63:0] translate_reg;
    logic [63:0] rotate_reg;
    logic [63:0] stretch_reg;
    logic [63:0] scale_reg;
    logic [63:0] turb_reg;
    logic [63:0] scroll_reg;

    logic signed [48:0] sprod_reg;
    logic signed [48:0] tprod_reg;
    logic signed [64:0] sc_u_prod_reg;
    logic signed [64:0] sc_v_prod_reg;
    logic [39:0]        sph_reg;
    logic [39:0]        tph_reg;
    logic signed [47:0] scroll_u_reg;
    logic signed [47:0] scroll_v_reg;
    logic signed [16:0] stab_reg;
    logic signed [32:0] w_reg;
    logic signed [31:0] recip_reg;

    logic                          div_start;
    logic                          div_done;
    logic [tcm_pkg::RECIP_QW-1:0]  div_q;
    logic [31:0]                   div_den;
    logic signed [tcm_pkg::RECIP_QW:0] q_signed;
    logic signed [32:0]            time_s;

    assign time_s    = $signed({1'b0, frame_time_reg});
    assign div_start = (state_reg == CS_DSTART);
    assign div_den   = 32'(w_reg[32] ? -w_reg : w_reg);
    assign q_signed  = w_reg[32] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:   state_next = CS_IDLE;
            CS_MUL:    state_next = CS_PHASE;
            CS_PHASE:  state_next = CS_LOOK;
            CS_LOOK:   state_next = CS_WAVE;
            CS_WAVE:   state_next = CS_DSTART;
            CS_DSTART: state_next = CS_DIV;
            CS_DIV:    state_next = div_done ? CS_IDLE : CS_DIV;
            default:   state_next = CS_IDLE;
        endcase
        // any write reruns the derived terms
        if (cfg_we)
            state_next = CS_MUL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CS_MUL;
            wave_modes_reg <= '0;
            frame_time_reg <= '0;
            translate_reg  <= '0;
            rotate_reg     <= 64'(tcm_pkg::ONE_VAL);
            stretch_reg    <= '0;
            scale_reg      <= {32'(tcm_pkg::ONE_VAL), 32'(tcm_pkg::ONE_VAL)};
            turb_reg       <= '0;
            scroll_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcm_pkg::CFG_WAVE_MODES: wave_modes_reg <= cfg_data[5:0];
                    tcm_pkg::CFG_FRAME_TIME: frame_time_reg <= cfg_data[31:0];
                    tcm_pkg::CFG_TRANSLATE:  translate_reg  <= cfg_data;
                    tcm_pkg::CFG_ROTATE:     rotate_reg     <= cfg_data;
                    tcm_pkg::CFG_STRETCH:    stretch_reg    <= cfg_data;
                    tcm_pkg::CFG_SCALE:      scale_reg      <= cfg_data;
                    tcm_pkg::CFG_TURB:       turb_reg       <= cfg_data;
                    tcm_pkg::CFG_SCROLL:     scroll_reg     <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    // derived terms, one step per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_MUL:
            begin
                sprod_reg     <= $signed(stretch_reg[63:48]) * time_s;
                tprod_reg     <= $signed(turb_reg[63:48]) * time_s;
                sc_u_prod_reg <= time_s * $signed(scroll_reg[31:0]);
                sc_v_prod_reg <= time_s * $signed(scroll_reg[63:32]);
            end
            CS_PHASE:
            begin
                sph_reg      <= {stretch_reg[39:32], 32'd0} + {sprod_reg[23:0], 16'd0};
                tph_reg      <= {turb_reg[39:32], 32'd0} + {tprod_reg[23:0], 16'd0};
                scroll_u_reg <= 48'(sc_u_prod_reg >>> 16);
                scroll_v_reg <= 48'(sc_v_prod_reg >>> 16);
            end
            CS_LOOK:
                stab_reg <= tcm_pkg::table_value(wave_modes_reg[2:0],
                                                 sph_reg[39 -: tcm_pkg::WAVE_LOG]);
            CS_WAVE:
                w_reg <= 33'(stab_reg * $signed(stretch_reg[31:16]))
                         + (33'($signed(stretch_reg[15:0])) <<< 14);
            CS_DIV:
            begin
                if (div_done)
                    recip_reg <= (w_reg == '0) ? 32'(tcm_pkg::ONE_VAL)
                                               : tcm_pkg::sat32(72'(q_signed));
            end
            default: ;
        endcase
    end

    tcm_recip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy = (state_reg != CS_IDLE);

    always_comb
    begin
        cfg.smode      = wave_modes_reg[2:0];
        cfg.tmode      = wave_modes_reg[5:3];
        cfg.trans_u    = $signed(translate_reg[31:0]);
        cfg.trans_v    = $signed(translate_reg[63:32]);
        cfg.cos_v      = $signed(rotate_reg[31:0]);
        cfg.sin_v      = $signed(rotate_reg[63:32]);
        cfg.recip      = recip_reg;
        cfg.scale_u    = $signed(scale_reg[31:0]);
        cfg.scale_v    = $signed(scale_reg[63:32]);
        cfg.turb_phase = tph_reg;
        cfg.turb_base  = $signed(turb_reg[15:0]);
        cfg.turb_amp   = $signed(turb_reg[31:16]);
        cfg.scroll_u   = scroll_u_reg;
        cfg.scroll_v   = scroll_v_reg;
    end

`ifndef ASSERT_OFF
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy) else $error("write did not start recompute");
    a_idle_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(div_done)) else $error("left recompute early");
`endif

endmodule

// ===== sv/tcm_pipe.sv =====
// Nine-stage vertex datapath: translate, rotate, stretch, scale, turbulence, scroll.
`timescale 1ns / 1ps

module tcm_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  tcm_pkg::in_item_t    in_item,
    input  tcm_pkg::cfg_view_t   cfg,
    output logic                 out_valid,
    output tcm_pkg::out_item_t   out_item
);

    localparam int LAT = 9;
    localparam int F   = tcm_pkg::FRACTION_BITS;
    localparam int WL  = tcm_pkg::WAVE_LOG;

    logic [LAT-1:0] vld_reg;
    logic [LAT-2:0] last_reg;

    logic signed [32:0] sum_xz;
    logic [39:0]        ru;
    logic [39:0]        rv;
    logic signed [32:0] du;
    logic signed [32:0] dv;
    logic signed [32:0] su;
    logic signed [32:0] sv;

    logic signed [31:0] s1_u_reg, s1_v_reg;
    logic [WL-1:0]      s1_ku_reg, s1_kv_reg;
    logic signed [64:0] s2_cu_reg, s2_sv_reg, s2_cv_reg, s2_su_reg;
    logic signed [16:0] s2_tu_reg, s2_tv_reg;
    logic signed [31:0] s3_u_reg, s3_v_reg;
    logic signed [32:0] s3_wu_reg, s3_wv_reg;
    logic signed [64:0] s4_pu_reg, s4_pv_reg;
    logic signed [31:0] s4_u_reg, s4_v_reg;
    logic signed [40:0] s4_tu_reg, s4_tv_reg;
    logic signed [31:0] s5_u_reg, s5_v_reg;
    logic signed [40:0] s5_tu_reg, s5_tv_reg;
    logic signed [63:0] s6_pu_reg, s6_pv_reg;
    logic signed [40:0] s6_tu_reg, s6_tv_reg;
    logic signed [31:0] s7_u_reg, s7_v_reg;
    logic signed [40:0] s7_tu_reg, s7_tv_reg;
    logic signed [31:0] s8_u_reg, s8_v_reg;
    tcm_pkg::out_item_t out_reg;

    always_comb
    begin
        sum_xz = 33'(in_item.pos_x) + 33'(in_item.pos_z);
        ru     = (40'(sum_xz) <<< tcm_pkg::TURB_SH) + cfg.turb_phase;
        rv     = (40'(in_item.pos_y) <<< tcm_pkg::TURB_SH) + cfg.turb_phase;
        du     = 33'(s1_u_reg) - 33'(tcm_pkg::HALF_VAL);
        dv     = 33'(s1_v_reg) - 33'(tcm_pkg::HALF_VAL);
        su     = 33'(s3_u_reg) - 33'(tcm_pkg::HALF_VAL);
        sv     = 33'(s3_v_reg) - 33'(tcm_pkg::HALF_VAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        last_reg <= {last_reg[LAT-3:0], in_item.last_in};

        // translate, and the turbulence table index
        s1_u_reg  <= tcm_pkg::sat32(72'(in_item.tex_u) + 72'(cfg.trans_u));
        s1_v_reg  <= tcm_pkg::sat32(72'(in_item.tex_v) + 72'(cfg.trans_v));
        s1_ku_reg <= ru[39 -: WL];
        s1_kv_reg <= rv[39 -: WL];

        // rotation products about the center
        s2_cu_reg <= cfg.cos_v * du;
        s2_sv_reg <= cfg.sin_v * dv;
        s2_cv_reg <= cfg.cos_v * dv;
        s2_su_reg <= cfg.sin_v * du;
        s2_tu_reg <= tcm_pkg::table_value(cfg.tmode, s1_ku_reg);
        s2_tv_reg <= tcm_pkg::table_value(cfg.tmode, s1_kv_reg);

        // floor each product on its own, then recombine
        s3_u_reg  <= tcm_pkg::sat32(72'(s2_cu_reg >>> F) - 72'(s2_sv_reg >>> F)
                                    + 72'(tcm_pkg::HALF_VAL));
        s3_v_reg  <= tcm_pkg::sat32(72'(s2_cv_reg >>> F) + 72'(s2_su_reg >>> F)
                                    + 72'(tcm_pkg::HALF_VAL));
        s3_wu_reg <= 33'(s2_tu_reg * cfg.turb_amp) + (33'(cfg.turb_base) <<< 14);
        s3_wv_reg <= 33'(s2_tv_reg * cfg.turb_amp) + (33'(cfg.turb_base) <<< 14);

        // stretch product
        s4_pu_reg <= su * cfg.recip;
        s4_pv_reg <= sv * cfg.recip;
        s4_u_reg  <= s3_u_reg;
        s4_v_reg  <= s3_v_reg;
        s4_tu_reg <= tcm_pkg::q22_to_coord(s3_wu_reg);
        s4_tv_reg <= tcm_pkg::q22_to_coord(s3_wv_reg);

        if (tcm_pkg::wave_on(cfg.smode))
        begin
            s5_u_reg <= tcm_pkg::sat32(72'(s4_pu_reg >>> F) + 72'(tcm_pkg::HALF_VAL));
            s5_v_reg <= tcm_pkg::sat32(72'(s4_pv_reg >>> F) + 72'(tcm_pkg::HALF_VAL));
        end
        else
        begin
            s5_u_reg <= s4_u_reg;
            s5_v_reg <= s4_v_reg;
        end
        s5_tu_reg <= s4_tu_reg;
        s5_tv_reg <= s4_tv_reg;

        // scale
        s6_pu_reg <= s5_u_reg * cfg.scale_u;
        s6_pv_reg <= s5_v_reg * cfg.scale_v;
        s6_tu_reg <= s5_tu_reg;
        s6_tv_reg <= s5_tv_reg;

        s7_u_reg  <= tcm_pkg::sat32(72'(s6_pu_reg >>> F));
        s7_v_reg  <= tcm_pkg::sat32(72'(s6_pv_reg >>> F));
        s7_tu_reg <= s6_tu_reg;
        s7_tv_reg <= s6_tv_reg;

        // turbulence
        if (tcm_pkg::wave_on(cfg.tmode))
        begin
            s8_u_reg <= tcm_pkg::sat32(72'(s7_u_reg) + 72'(s7_tu_reg));
            s8_v_reg <= tcm_pkg::sat32(72'(s7_v_reg) + 72'(s7_tv_reg));
        end
        else
        begin
            s8_u_reg <= s7_u_reg;
            s8_v_reg <= s7_v_reg;
        end

        // scroll
        out_reg.out_u    <= tcm_pkg::sat32(72'(s8_u_reg) + 72'(cfg.scroll_u));
        out_reg.out_v    <= tcm_pkg::sat32(72'(s8_v_reg) + 72'(cfg.scroll_v));
        out_reg.last_out <= last_reg[LAT-2];
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_item  = out_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid == $past(in_valid, LAT)) else $error("item lost or invented in pipe");
`endif

endmodule

// ===== sv/texture_coord_modifier_top.sv =====
// Top level of the texture coordinate modifier.
`timescale 1ns / 1ps

// Texture coordinate modifier: one vertex in, one modified (u,v) out.
// Input: drive vertex and raise start; the item is taken at a clock edge
// with start high and busy low. Items may be offered every cycle.
// Output: done is high for exactly one cycle with result valid; results
// leave in input order and the receiver cannot stall them.
// Throughput is one item per cycle while busy is low, set by the
// nine-stage datapath.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge,
// only while no items are in flight, which the user must keep; the block
// does not enforce it. Each write reruns the per-frame terms (wave phases,
// scroll offsets, the stretch reciprocal from a bit-serial divider),
// holding busy high until the divider is done. Reset: config registers and
// valid flags reset and the same recompute runs, holding busy high too.
module texture_coord_modifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tcm_pkg::in_item_t             vertex,
    output logic                          done,
    output tcm_pkg::out_item_t            result,
    input  logic                          cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    tcm_pkg::cfg_view_t cfg;
    logic               accept;

    assign accept = start && !busy;

    tcm_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg       (cfg)
    );

    tcm_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (vertex),
        .cfg       (cfg),
        .out_valid (done),
        .out_item  (result)
    );

endmodule
